>>> design/nlms_adaptive_fir_dc_removal_macros.svh
// Assertion macros used by the checker file of the NLMS filter block.
`ifndef NLMS_ADAPTIVE_FIR_DC_REMOVAL_MACROS_SVH
`define NLMS_ADAPTIVE_FIR_DC_REMOVAL_MACROS_SVH

// Consequent must hold in the cycle after the antecedent, outside reset.
`define NLMS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Consequent must hold in the same cycle as the antecedent, outside reset.
`define NLMS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent in the following cycle, checked during reset as well.
`define NLMS_ASSERT_NEXT_ALWAYS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/nlms_pkg.sv
// Package with types and constants of the NLMS filter with DC removal.
`timescale 1ns / 1ps
package nlms_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int CFG_W      = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int DC_W       = 24;
  localparam int WGT_W      = 32;
  localparam int MUL_A_W    = 32;
  localparam int MUL_B_W    = 25;
  localparam int MUL_P_W    = MUL_A_W + MUL_B_W;
  localparam int NUM_W      = 58;
  localparam int DIV_CNT_W  = 6;
  localparam int TAPS_DEF   = 100;

  localparam logic [CFG_W-1:0] STEP_SIZE_RST    = 16'd13107;
  localparam logic [CFG_W-1:0] DC_SMOOTHING_RST = 16'd19661;

  localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DC_SMOOTHING = 2'd1;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DC_A,
    ST_DC_B,
    ST_DC_C,
    ST_CORR,
    ST_PW_A,
    ST_PW_B,
    ST_FIR_A,
    ST_FIR_B,
    ST_FIR_C,
    ST_ERR,
    ST_MU,
    ST_UPD_K,
    ST_UPD_R,
    ST_UPD_B,
    ST_DIV0,
    ST_DIV,
    ST_UPD_W,
    ST_DONE
  } state_t;

endpackage

>>> design/nlms_adaptive_fir_dc_removal.sv
// Top level of the NLMS adaptive FIR filter with DC tracking and removal.
//
//   channel | ports                                   | direction
//   in      | in_valid, in_stall, in_sample_in        | item in
//   out     | out_valid, out_stall, out_sample_out    | item out
//   cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data | register write
//
// A new item is taken only after the previous one has been fully processed.
// The weight update runs a radix-2 divider per tap with 58 steps.
// When the delay line holds zero energy the update pass is skipped.
// After reset a clearing pass zeroes both memories; no item is taken.
// A stalled result only holds the block once the next result is ready.
`timescale 1ns / 1ps
module nlms_adaptive_fir_dc_removal #(
  parameter int TAPS = nlms_pkg::TAPS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [nlms_pkg::SAMPLE_W-1:0]   in_sample_in,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [nlms_pkg::SAMPLE_W-1:0]   out_sample_out,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [nlms_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [nlms_pkg::CFG_W-1:0]             cfg_data
);

  localparam int IDX_W = $clog2(TAPS);
  localparam int PW_W  = 31 + $clog2(TAPS);
  localparam int AW    = 48 + $clog2(TAPS);
  localparam int UW    = nlms_pkg::NUM_W + 2;
  localparam logic [IDX_W-1:0] LAST = IDX_W'(TAPS - 1);

  nlms_pkg::state_t state_r, state_nxt;

  logic [IDX_W-1:0] i_r, d_idx_r, pos_r;
  logic [nlms_pkg::CFG_W-1:0] step_r, dcs_r;
  logic signed [nlms_pkg::DC_W-1:0] dc_r;
  logic signed [nlms_pkg::SAMPLE_W-1:0] x_r, c_r, e_r;
  logic signed [AW-1:0] acc_r;
  logic signed [nlms_pkg::MUL_P_W-1:0] prod_r;
  logic [PW_W-1:0] power_r, rem_r;
  logic signed [nlms_pkg::WGT_W-1:0] k_r;
  logic [nlms_pkg::NUM_W-1:0] num_r, q_r;
  logic neg_r;
  logic [nlms_pkg::DIV_CNT_W-1:0] cnt_r;
  logic out_valid_r;
  logic signed [nlms_pkg::SAMPLE_W-1:0] out_sample_r;
  logic signed [nlms_pkg::SAMPLE_W-1:0] rd_d_r;
  logic signed [nlms_pkg::WGT_W-1:0] rd_w_r;

  logic signed [nlms_pkg::SAMPLE_W-1:0] dl_mem [TAPS];
  logic signed [nlms_pkg::WGT_W-1:0]    w_mem  [TAPS];

  // Control decoded from the state.
  logic accept, ld_out, dl_we, w_we;
  logic [IDX_W-1:0] dl_waddr;
  logic signed [nlms_pkg::SAMPLE_W-1:0] dl_wdata;
  logic signed [nlms_pkg::WGT_W-1:0] w_wdata;
  logic signed [nlms_pkg::MUL_A_W-1:0] mul_a;
  logic signed [nlms_pkg::MUL_B_W-1:0] mul_b;
  logic signed [nlms_pkg::MUL_P_W-1:0] mul_p;

  // Arithmetic around the shared multiplier.
  logic signed [AW-1:0] dc_t, dc_sh;
  logic signed [nlms_pkg::DC_W-1:0] dc_new;
  logic signed [25:0] cv, cvb;
  logic signed [17:0] cq;
  logic signed [nlms_pkg::SAMPLE_W-1:0] c_new, e_new;
  logic signed [AW-1:0] ev, evb, eq;
  logic signed [nlms_pkg::MUL_P_W-1:0] p_abs;
  logic [PW_W:0] rem2;
  logic div_ge;
  logic signed [UW-1:0] delta, wsum;
  logic signed [nlms_pkg::WGT_W-1:0] w_new;

  assign mul_p = nlms_pkg::MUL_P_W'(mul_a) * nlms_pkg::MUL_P_W'(mul_b);

  assign accept         = in_valid && !in_stall;
  assign cfg_ready      = 1'b1;
  assign out_valid      = out_valid_r;
  assign out_sample_out = out_sample_r;

  always_comb begin
    dc_t = acc_r + (AW'(prod_r) <<< 8) + AW'(32768);
    dc_sh = dc_t >>> 16;
    if (dc_sh > AW'(8388607)) begin
      dc_new = 24'sh7FFFFF;
    end else if (dc_sh < AW'(-8388608)) begin
      dc_new = -24'sh800000;
    end else begin
      dc_new = nlms_pkg::DC_W'(dc_sh);
    end

    // Corrected sample, rounded toward zero.
    cv  = 26'(signed'({x_r, 8'b0})) - 26'(dc_r);
    cvb = cv + ((cv < 0) ? 26'sd255 : 26'sd0);
    cq  = 18'(cvb >>> 8);
    if (cq > 18'sd32767) begin
      c_new = 16'sh7FFF;
    end else if (cq < -18'sd32768) begin
      c_new = -16'sh8000;
    end else begin
      c_new = nlms_pkg::SAMPLE_W'(cq);
    end

    ev  = (AW'(c_r) <<< 28) - acc_r;
    evb = ev + ((ev < 0) ? AW'(268435455) : AW'(0));
    eq  = evb >>> 28;
    if (eq > AW'(32767)) begin
      e_new = 16'sh7FFF;
    end else if (eq < AW'(-32768)) begin
      e_new = -16'sh8000;
    end else begin
      e_new = nlms_pkg::SAMPLE_W'(eq);
    end

    p_abs = prod_r[nlms_pkg::MUL_P_W-1] ? -prod_r : prod_r;

    rem2   = {rem_r, num_r[nlms_pkg::NUM_W-1]};
    div_ge = rem2 >= {1'b0, power_r};

    delta = neg_r ? -UW'({2'b0, q_r}) : UW'({2'b0, q_r});
    wsum  = UW'(rd_w_r) + delta;
    if (wsum > UW'(64'sh7FFFFFFF)) begin
      w_new = 32'sh7FFFFFFF;
    end else if (wsum < -UW'(64'sh80000000)) begin
      w_new = -32'sh80000000;
    end else begin
      w_new = nlms_pkg::WGT_W'(wsum);
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      nlms_pkg::ST_CLEAR: if (i_r == LAST) state_nxt = nlms_pkg::ST_IDLE;
      nlms_pkg::ST_IDLE:  if (in_valid) state_nxt = nlms_pkg::ST_DC_A;
      nlms_pkg::ST_DC_A:  state_nxt = nlms_pkg::ST_DC_B;
      nlms_pkg::ST_DC_B:  state_nxt = nlms_pkg::ST_DC_C;
      nlms_pkg::ST_DC_C:  state_nxt = nlms_pkg::ST_CORR;
      nlms_pkg::ST_CORR:  state_nxt = nlms_pkg::ST_PW_A;
      nlms_pkg::ST_PW_A:  state_nxt = nlms_pkg::ST_PW_B;
      nlms_pkg::ST_PW_B:  state_nxt = nlms_pkg::ST_FIR_A;
      nlms_pkg::ST_FIR_A: state_nxt = nlms_pkg::ST_FIR_B;
      nlms_pkg::ST_FIR_B: state_nxt = nlms_pkg::ST_FIR_C;
      nlms_pkg::ST_FIR_C: begin
        state_nxt = (i_r == LAST) ? nlms_pkg::ST_ERR : nlms_pkg::ST_FIR_A;
      end
      nlms_pkg::ST_ERR: begin
        if (!out_valid_r || !out_stall) begin
          state_nxt = (power_r == '0) ? nlms_pkg::ST_DONE : nlms_pkg::ST_MU;
        end
      end
      nlms_pkg::ST_MU:    state_nxt = nlms_pkg::ST_UPD_K;
      nlms_pkg::ST_UPD_K: state_nxt = nlms_pkg::ST_UPD_B;
      nlms_pkg::ST_UPD_R: state_nxt = nlms_pkg::ST_UPD_B;
      nlms_pkg::ST_UPD_B: state_nxt = nlms_pkg::ST_DIV0;
      nlms_pkg::ST_DIV0:  state_nxt = nlms_pkg::ST_DIV;
      nlms_pkg::ST_DIV: begin
        if (cnt_r == nlms_pkg::DIV_CNT_W'(nlms_pkg::NUM_W - 1)) begin
          state_nxt = nlms_pkg::ST_UPD_W;
        end
      end
      nlms_pkg::ST_UPD_W: begin
        state_nxt = (i_r == LAST) ? nlms_pkg::ST_DONE : nlms_pkg::ST_UPD_R;
      end
      nlms_pkg::ST_DONE:  state_nxt = nlms_pkg::ST_IDLE;
      default:            state_nxt = nlms_pkg::ST_CLEAR;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    in_stall = (state_r != nlms_pkg::ST_IDLE);
    ld_out   = (state_r == nlms_pkg::ST_ERR) && (!out_valid_r || !out_stall);
    dl_we    = 1'b0;
    w_we     = 1'b0;
    dl_waddr = pos_r;
    dl_wdata = c_r;
    w_wdata  = w_new;
    mul_a    = '0;
    mul_b    = '0;
    unique case (state_r)
      nlms_pkg::ST_CLEAR: begin
        dl_we    = 1'b1;
        w_we     = 1'b1;
        dl_waddr = i_r;
        dl_wdata = '0;
        w_wdata  = '0;
      end
      nlms_pkg::ST_DC_A: begin
        mul_a = signed'(nlms_pkg::MUL_A_W'(17'h10000 - {1'b0, dcs_r}));
        mul_b = nlms_pkg::MUL_B_W'(dc_r);
      end
      nlms_pkg::ST_DC_B: begin
        mul_a = signed'(nlms_pkg::MUL_A_W'(dcs_r));
        mul_b = nlms_pkg::MUL_B_W'(x_r);
      end
      nlms_pkg::ST_CORR: begin
        mul_a = nlms_pkg::MUL_A_W'(rd_d_r);
        mul_b = nlms_pkg::MUL_B_W'(rd_d_r);
      end
      nlms_pkg::ST_PW_A: begin
        dl_we = 1'b1;
        mul_a = nlms_pkg::MUL_A_W'(c_r);
        mul_b = nlms_pkg::MUL_B_W'(c_r);
      end
      nlms_pkg::ST_FIR_B: begin
        mul_a = rd_w_r;
        mul_b = nlms_pkg::MUL_B_W'(rd_d_r);
      end
      nlms_pkg::ST_MU: begin
        mul_a = signed'(nlms_pkg::MUL_A_W'(step_r));
        mul_b = nlms_pkg::MUL_B_W'(e_r);
      end
      nlms_pkg::ST_UPD_B: begin
        mul_a = k_r;
        mul_b = nlms_pkg::MUL_B_W'(rd_d_r);
      end
      nlms_pkg::ST_UPD_W: w_we = 1'b1;
      default: ;
    endcase
  end

  // Memories with registered reads.
  always_ff @(posedge clk) begin
    if (dl_we) begin
      dl_mem[dl_waddr] <= dl_wdata;
    end
    rd_d_r <= dl_mem[d_idx_r];
  end

  always_ff @(posedge clk) begin
    if (w_we) begin
      w_mem[i_r] <= w_wdata;
    end
    rd_w_r <= w_mem[i_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= nlms_pkg::ST_CLEAR;
      i_r         <= '0;
      d_idx_r     <= '0;
      pos_r       <= '0;
      power_r     <= '0;
      dc_r        <= '0;
      step_r      <= nlms_pkg::STEP_SIZE_RST;
      dcs_r       <= nlms_pkg::DC_SMOOTHING_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          nlms_pkg::REG_STEP_SIZE:    step_r <= cfg_data;
          nlms_pkg::REG_DC_SMOOTHING: dcs_r  <= cfg_data;
          default: ;
        endcase
      end

      if (ld_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        nlms_pkg::ST_CLEAR: i_r <= (i_r == LAST) ? '0 : i_r + 1'b1;
        nlms_pkg::ST_IDLE:  if (accept) d_idx_r <= pos_r;
        nlms_pkg::ST_DC_C:  dc_r <= dc_new;
        nlms_pkg::ST_PW_A:  power_r <= power_r - PW_W'(prod_r);
        nlms_pkg::ST_PW_B: begin
          power_r <= power_r + PW_W'(prod_r);
          i_r     <= '0;
        end
        nlms_pkg::ST_FIR_C, nlms_pkg::ST_UPD_W: begin
          i_r     <= (i_r == LAST) ? '0 : i_r + 1'b1;
          d_idx_r <= (d_idx_r == '0) ? LAST : d_idx_r - 1'b1;
        end
        nlms_pkg::ST_DONE:  pos_r <= (pos_r == LAST) ? '0 : pos_r + 1'b1;
        default: ;
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    prod_r <= mul_p;
    if (ld_out) begin
      out_sample_r <= e_new;
    end
    unique case (state_r)
      nlms_pkg::ST_IDLE:  if (accept) x_r <= in_sample_in;
      nlms_pkg::ST_DC_B:  acc_r <= AW'(prod_r);
      nlms_pkg::ST_CORR:  c_r <= c_new;
      nlms_pkg::ST_PW_B:  acc_r <= '0;
      nlms_pkg::ST_FIR_C: acc_r <= acc_r + AW'(prod_r);
      nlms_pkg::ST_ERR:   e_r <= e_new;
      nlms_pkg::ST_UPD_K: k_r <= nlms_pkg::WGT_W'(prod_r);
      nlms_pkg::ST_DIV0: begin
        // Numerator magnitude is |mu * e * tap| scaled by 4096.
        neg_r <= prod_r[nlms_pkg::MUL_P_W-1];
        num_r <= {p_abs[45:0], 12'b0};
        rem_r <= '0;
        q_r   <= '0;
        cnt_r <= '0;
      end
      nlms_pkg::ST_DIV: begin
        rem_r <= div_ge ? PW_W'(rem2 - {1'b0, power_r}) : PW_W'(rem2);
        q_r   <= {q_r[nlms_pkg::NUM_W-2:0], div_ge};
        num_r <= num_r << 1;
        cnt_r <= cnt_r + 1'b1;
      end
      default: ;
    endcase
  end

endmodule

>>> design/nlms_chk.sv
// Port checker for the NLMS filter block, bound to its top level.
`timescale 1ns / 1ps
`include "nlms_adaptive_fir_dc_removal_macros.svh"
module nlms_chk (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 in_valid,
  input logic                                 in_stall,
  input logic                                 out_valid,
  input logic                                 out_stall,
  input logic signed [nlms_pkg::SAMPLE_W-1:0] out_sample_out
);

  `NLMS_ASSERT_NEXT_ALWAYS(a_rst_out, !rst_n, !out_valid, "result valid after reset")
  `NLMS_ASSERT_NEXT(a_busy_after_in, in_valid && !in_stall, in_stall, "second item taken while busy")
  `NLMS_ASSERT_NOW(a_result_busy, $rose(out_valid), in_stall, "result appeared while idle")
  `NLMS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_sample_out), "stalled result changed")

endmodule

bind nlms_adaptive_fir_dc_removal nlms_chk u_nlms_chk (.*);
